// ===== rtl/core/sensor_moving_average_top_defines.svh =====
`ifndef SENSOR_MOVING_AVERAGE_TOP_DEFINES_SVH
`define SENSOR_MOVING_AVERAGE_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SMA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SMA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/sma_pkg.sv =====
`timescale 1ns / 1ps

package sma_pkg;

	localparam int MAX_WINDOW_DEF = 16;
	localparam int RAW_W          = 12;
	localparam int SAMPLE_W       = 14;
	localparam int OFF_W          = 8;
	localparam int LEN_FIELD_W    = 5;
	localparam int CFG_DATA_W     = 8;
	localparam int CFG_IDX_W      = 2;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_OFFSET     = 2'd1;

	localparam int OPEN_CODE  = 4095;
	localparam int FILL_VALUE = 20;
	localparam int RESET_LEN  = 5;

	typedef struct packed {
		logic load;
		logic update;
		logic div_start;
		logic div_step;
		logic div_finish;
		logic out_load;
	} sma_cmd_t;

	typedef struct packed {
		logic fault;
	} sma_status_t;

endpackage

// ===== rtl/core/sensor_moving_average_top.sv =====
`timescale 1ns / 1ps
// A normal item passes through calc, divider start, the divider steps (one bit per cycle
// of the SUM_W-bit sum, SUM_W = 14 + log2 of the window depth), divider end and output;
// a fault item goes from calc straight to output. No new item is taken until it leaves.
// A finished result waits in the output register while the next item is taken.
// Reset (asynchronous, active low): length 5, offset 0, sum 100, last average 4095;
// window entries read as 20 through per-entry valid bits, so no clearing pass is needed.

`include "sensor_moving_average_top_defines.svh"

module sensor_moving_average_top #(
	parameter int MAX_WINDOW = sma_pkg::MAX_WINDOW_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [sma_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [sma_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [sma_pkg::RAW_W-1:0]            raw_sample,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [sma_pkg::SAMPLE_W-1:0]  average_temperature,
	output logic                                 sensor_fault
);

	localparam int SUM_W = sma_pkg::SAMPLE_W + $clog2(MAX_WINDOW);

	sma_pkg::sma_cmd_t    cmd;
	sma_pkg::sma_status_t status;

	sma_ctrl #(
		.DIV_STEPS (SUM_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	sma_dp #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_we              (cfg_we),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.raw_sample          (raw_sample),
		.cmd                 (cmd),
		.status              (status),
		.average_temperature (average_temperature),
		.sensor_fault        (sensor_fault)
	);

	`SMA_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall, "item accepted but input not stalled next cycle")
	`SMA_ASSERT_NOW(a_no_overwrite, clk, arst_n, cmd.out_load, !out_valid || !out_stall, "output register overwritten while result still pending")
	`SMA_ASSERT_NOW(a_fault_keeps_window, clk, arst_n, cmd.update, !status.fault, "window updated with an open-sensor sample")

endmodule

// ===== rtl/core/sma_ctrl.sv =====
`timescale 1ns / 1ps

module sma_ctrl #(
	parameter int DIV_STEPS = 18
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  sma_pkg::sma_status_t status,
	output sma_pkg::sma_cmd_t    cmd
);

	localparam int CNT_W = $clog2(DIV_STEPS + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CALC,
		ST_DIV_INIT,
		ST_DIV,
		ST_DIV_END,
		ST_OUT
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               out_valid_q;
	logic               slot_free;

	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE:     cmd.load       = in_valid;
			ST_CALC:     cmd.update     = !status.fault;
			ST_DIV_INIT: cmd.div_start  = 1'b1;
			ST_DIV:      cmd.div_step   = 1'b1;
			ST_DIV_END:  cmd.div_finish = 1'b1;
			ST_OUT:      cmd.out_load   = slot_free;
			default:     cmd            = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					// A discarded sample goes straight out with the held average.
					state_q <= status.fault ? ST_OUT : ST_DIV_INIT;
				end
				ST_DIV_INIT: begin
					cnt_q   <= CNT_W'(DIV_STEPS);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1)) begin
						state_q <= ST_DIV_END;
					end
				end
				ST_DIV_END: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/sma_dp.sv =====
`timescale 1ns / 1ps

module sma_dp #(
	parameter int MAX_WINDOW = sma_pkg::MAX_WINDOW_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_we,
	input  logic [sma_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  logic [sma_pkg::CFG_DATA_W-1:0]          cfg_data,
	input  logic [sma_pkg::RAW_W-1:0]               raw_sample,
	input  sma_pkg::sma_cmd_t                       cmd,
	output sma_pkg::sma_status_t                    status,
	output logic signed [sma_pkg::SAMPLE_W-1:0]     average_temperature,
	output logic                                    sensor_fault
);

	localparam int SAMPLE_W = sma_pkg::SAMPLE_W;
	localparam int SUM_W    = SAMPLE_W + $clog2(MAX_WINDOW);
	localparam int LEN_W    = $clog2(MAX_WINDOW + 1);
	localparam int PTR_W    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int RST_LEN  = (sma_pkg::RESET_LEN > MAX_WINDOW) ? MAX_WINDOW
		: sma_pkg::RESET_LEN;
	localparam logic signed [SUM_W-1:0]    RST_SUM = SUM_W'(sma_pkg::FILL_VALUE * RST_LEN);
	localparam logic signed [SAMPLE_W-1:0] FILL    = SAMPLE_W'(sma_pkg::FILL_VALUE);
	localparam logic signed [SAMPLE_W-1:0] OPEN    = SAMPLE_W'(sma_pkg::OPEN_CODE);

	// Configuration and window bookkeeping.
	logic [LEN_W-1:0]                   len_q;
	logic signed [sma_pkg::OFF_W-1:0]   off_q;
	logic signed [SUM_W-1:0]            sum_q;
	logic [PTR_W-1:0]                   pos_q;
	logic [MAX_WINDOW-1:0]              vld_q;
	logic signed [SAMPLE_W-1:0]         avg_q;

	logic signed [SAMPLE_W-1:0]         win_mem [MAX_WINDOW];
	logic signed [SAMPLE_W-1:0]         rd_q;
	logic                               rd_vld_q;
	logic signed [SAMPLE_W-1:0]         sample_q;

	// Divider registers: the dividend magnitude shifts out at the top while
	// quotient bits shift in at the bottom.
	logic [SUM_W-1:0]                   dvd_q;
	logic [LEN_W-1:0]                   rem_q;
	logic                               neg_q;

	logic [sma_pkg::LEN_FIELD_W-1:0]    len_field;
	logic [LEN_W-1:0]                   len_new;
	logic [SUM_W-1:0]                   sum_reload;
	logic signed [SAMPLE_W-1:0]         corrected;
	logic signed [SAMPLE_W-1:0]         old_val;
	logic signed [SUM_W-1:0]            sum_new;
	logic [LEN_W-1:0]                   pos_inc;
	logic [PTR_W-1:0]                   pos_next;
	logic [SUM_W-1:0]                   abs_sum;
	logic [LEN_W:0]                     trial;
	logic                               ge;
	logic [LEN_W-1:0]                   rem_n;
	logic signed [SAMPLE_W-1:0]         quot;
	logic signed [SAMPLE_W-1:0]         avg_new;

	assign len_field = cfg_data[sma_pkg::LEN_FIELD_W-1:0];

	always_comb begin
		if (len_field == '0) begin
			len_new = LEN_W'(1);
		end else if (32'(len_field) > 32'(MAX_WINDOW)) begin
			len_new = LEN_W'(MAX_WINDOW);
		end else begin
			len_new = LEN_W'(len_field);
		end
	end

	// Twenty times the length, as two shifted copies.
	assign sum_reload = (SUM_W'(len_new) << 4) + (SUM_W'(len_new) << 2);

	assign corrected = $signed({{(SAMPLE_W - sma_pkg::RAW_W){1'b0}}, raw_sample})
		- {{(SAMPLE_W - sma_pkg::OFF_W){off_q[sma_pkg::OFF_W-1]}}, off_q};

	assign status.fault = (sample_q == OPEN);

	// An entry not written since reset or the last length reload reads as the fill value.
	assign old_val = rd_vld_q ? rd_q : FILL;
	assign sum_new = sum_q - SUM_W'(old_val) + SUM_W'(sample_q);

	assign pos_inc  = LEN_W'(pos_q) + LEN_W'(1);
	assign pos_next = (pos_inc == len_q) ? '0 : PTR_W'(pos_inc);

	assign abs_sum = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign trial   = {rem_q, dvd_q[SUM_W-1]};
	assign ge      = (trial >= {1'b0, len_q});
	assign rem_n   = ge ? LEN_W'(trial - {1'b0, len_q}) : trial[LEN_W-1:0];

	assign quot    = $signed(dvd_q[SAMPLE_W-1:0]);
	assign avg_new = neg_q ? -quot : quot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_W'(RST_LEN);
			off_q <= '0;
			sum_q <= RST_SUM;
			pos_q <= '0;
			vld_q <= '0;
			avg_q <= OPEN;
		end else begin
			if (cfg_we && cfg_index == sma_pkg::REG_WINDOW_LENGTH) begin
				len_q <= len_new;
				sum_q <= $signed(sum_reload);
				pos_q <= '0;
				vld_q <= '0;
			end else if (cfg_we && cfg_index == sma_pkg::REG_CAL_OFFSET) begin
				off_q <= $signed(cfg_data[sma_pkg::OFF_W-1:0]);
			end
			if (cmd.update) begin
				sum_q        <= sum_new;
				pos_q        <= pos_next;
				vld_q[pos_q] <= 1'b1;
			end
			if (cmd.div_finish) begin
				avg_q <= avg_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			win_mem[pos_q] <= sample_q;
		end
		rd_q <= win_mem[pos_q];
	end

	always_ff @(posedge clk) begin
		rd_vld_q <= vld_q[pos_q];
		if (cmd.load) begin
			sample_q <= corrected;
		end
		if (cmd.div_start) begin
			dvd_q <= abs_sum;
			rem_q <= '0;
			neg_q <= sum_q[SUM_W-1];
		end
		if (cmd.div_step) begin
			dvd_q <= {dvd_q[SUM_W-2:0], ge};
			rem_q <= rem_n;
		end
		if (cmd.out_load) begin
			average_temperature <= avg_q;
			sensor_fault        <= status.fault;
		end
	end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	localparam int WINDOW_MAX = sma_pkg::MAX_WINDOW_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD = 300;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS = 100;
	localparam logic [sma_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [sma_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	typedef struct packed {
		logic signed [sma_pkg::SAMPLE_W-1:0] average;
		logic                                fault;
	} reading_result_t;

	typedef struct packed {
		bit                              is_reg;
		logic [sma_pkg::CFG_IDX_W-1:0]   idx;
		logic [sma_pkg::CFG_DATA_W-1:0]  data;
		logic [sma_pkg::RAW_W-1:0]       raw;
		bit                              known;
		logic signed [sma_pkg::SAMPLE_W-1:0] avg;
		logic                            fault;
	} bench_row_t;

	logic                                clk;
	logic                                arst_n;
	logic                                cfg_we;
	logic [sma_pkg::CFG_IDX_W-1:0]       cfg_index;
	logic [sma_pkg::CFG_DATA_W-1:0]      cfg_data;
	logic                                in_valid;
	logic                                in_stall;
	logic [sma_pkg::RAW_W-1:0]           raw_sample;
	logic                                out_valid;
	logic                                out_stall;
	logic signed [sma_pkg::SAMPLE_W-1:0] average_temperature;
	logic                                sensor_fault;

	// Shadow copy of the filter state.
	int  avg_window [WINDOW_MAX];
	int  window_total;
	int  slot_index;
	int  shown_average;
	int  avg_len;
	int  cal_offset;

	reading_result_t pending_results[$];
	bench_row_t      directed_rows[$];
	int              mismatch_count;
	int              cycle_count;
	int              hold_point;
	bit              tx_burst;
	bit              rx_burst;

	sensor_moving_average_top u_dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_we              (cfg_we),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.raw_sample          (raw_sample),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.average_temperature (average_temperature),
		.sensor_fault        (sensor_fault)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic void refill_window();
		for (int i = 0; i < WINDOW_MAX; i++)
			avg_window[i] = sma_pkg::FILL_VALUE;
		window_total = sma_pkg::FILL_VALUE * avg_len;
		slot_index = 0;
	endfunction

	function automatic void apply_reg(input logic [sma_pkg::CFG_IDX_W-1:0] idx,
			input logic [sma_pkg::CFG_DATA_W-1:0] data);
		int len;
		if (idx == sma_pkg::REG_WINDOW_LENGTH) begin
			len = int'(data[sma_pkg::LEN_FIELD_W-1:0]);
			if (len < 1)
				len = 1;
			if (len > WINDOW_MAX)
				len = WINDOW_MAX;
			avg_len = len;
			refill_window();
		end else if (idx == sma_pkg::REG_CAL_OFFSET) begin
			cal_offset = $signed(data);
		end
	endfunction

	function automatic reading_result_t predict_reading(input logic [sma_pkg::RAW_W-1:0] raw);
		reading_result_t res;
		int corrected;
		corrected = int'(raw) - cal_offset;
		res.fault = (corrected == sma_pkg::OPEN_CODE);
		if (!res.fault) begin
			if (slot_index >= avg_len)
				slot_index = 0;
			window_total = window_total - avg_window[slot_index] + corrected;
			avg_window[slot_index] = corrected;
			slot_index = slot_index + 1;
			if (slot_index >= avg_len)
				slot_index = 0;
			// Integer division here truncates toward zero, as the block must.
			shown_average = window_total / avg_len;
		end
		res.average = shown_average[sma_pkg::SAMPLE_W-1:0];
		return res;
	endfunction

	task automatic add_reg(input logic [sma_pkg::CFG_IDX_W-1:0] idx,
			input logic [sma_pkg::CFG_DATA_W-1:0] data);
		bench_row_t row;
		row = '0;
		row.is_reg = 1'b1;
		row.idx = idx;
		row.data = data;
		directed_rows.push_back(row);
	endtask

	task automatic add_item(input logic [sma_pkg::RAW_W-1:0] raw, input bit known,
			input logic signed [sma_pkg::SAMPLE_W-1:0] avg, input logic fault);
		bench_row_t row;
		row = '0;
		row.raw = raw;
		row.known = known;
		row.avg = avg;
		row.fault = fault;
		directed_rows.push_back(row);
	endtask

	// Waits until every expected result has come back, with the input quiet.
	task automatic drain_filter();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic write_reg(input logic [sma_pkg::CFG_IDX_W-1:0] idx,
			input logic [sma_pkg::CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		apply_reg(idx, data);
	endtask

	task automatic offer_reading(input logic [sma_pkg::RAW_W-1:0] raw, input bit known,
			input logic signed [sma_pkg::SAMPLE_W-1:0] avg, input logic fault);
		int gap;
		reading_result_t res;
		if ($urandom_range(0, 49) == 0)
			tx_burst = !tx_burst;
		gap = tx_burst ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		raw_sample <= raw;
		do @(posedge clk); while (in_stall);
		res = predict_reading(raw);
		if (known) begin
			res.average = avg;
			res.fault = fault;
		end
		pending_results.push_back(res);
	endtask

	function automatic logic [sma_pkg::RAW_W-1:0] draw_reading();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			// Aim at the open-sensor code after the offset, where it is reachable.
			if (cal_offset <= 0)
				return sma_pkg::RAW_W'(sma_pkg::OPEN_CODE + cal_offset);
			return sma_pkg::RAW_W'(sma_pkg::OPEN_CODE);
		end
		if (pick == 1)
			return $urandom_range(0, 1) ? '1 : '0;
		return sma_pkg::RAW_W'($urandom_range(0, sma_pkg::OPEN_CODE));
	endfunction

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		reading_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected result: avg %0d fault %0b", $time,
					average_temperature, sensor_fault);
			end else begin
				want = pending_results.pop_front();
				if (average_temperature !== want.average) begin
					mismatch_count++;
					$display("%0t: average_temperature expected %0d actual %0d", $time,
						want.average, average_temperature);
				end
				if (sensor_fault !== want.fault) begin
					mismatch_count++;
					$display("%0t: sensor_fault expected %0b actual %0b", $time,
						want.fault, sensor_fault);
				end
			end
		end
	end

	// Result side: random stalls per item, one long hold so the filter backs up.
	initial begin
		int hold;
		int taken;
		taken = 0;
		wait (arst_n);
		forever begin
			if ($urandom_range(0, 49) == 0)
				rx_burst = !rx_burst;
			hold = rx_burst ? 0 : $urandom_range(0, 8);
			if (taken == hold_point)
				hold = LONG_HOLD;
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			taken++;
		end
	end

	initial begin
		logic [sma_pkg::CFG_DATA_W-1:0] len_data;
		logic [sma_pkg::CFG_DATA_W-1:0] off_data;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		raw_sample = '0;
		out_stall = 1'b0;
		mismatch_count = 0;
		cycle_count = 0;
		tx_burst = 1'b0;
		rx_burst = 1'b0;
		hold_point = $urandom_range(150, 400);
		avg_len = sma_pkg::RESET_LEN;
		cal_offset = 0;
		shown_average = sma_pkg::OPEN_CODE;
		refill_window();

		// Directed rows: reset state, extremes of offset and length, open sensor,
		// ignored register indexes, and negative sums that truncate toward zero.
		add_item(12'd4095, 1'b1, 14'sd4095, 1'b1);
		add_item(12'd0, 1'b0, '0, 1'b0);
		add_item(12'd4094, 1'b0, '0, 1'b0);
		add_reg(sma_pkg::REG_WINDOW_LENGTH, 8'd1);
		add_item(12'd4094, 1'b1, 14'sd4094, 1'b0);
		add_item(12'd0, 1'b1, 14'sd0, 1'b0);
		add_reg(sma_pkg::REG_CAL_OFFSET, 8'h7F);
		add_item(12'd0, 1'b1, -14'sd127, 1'b0);
		add_item(12'd4095, 1'b1, 14'sd3968, 1'b0);
		add_reg(sma_pkg::REG_CAL_OFFSET, 8'h80);
		add_item(12'd4095, 1'b1, 14'sd4223, 1'b0);
		add_item(12'd0, 1'b1, 14'sd128, 1'b0);
		add_reg(sma_pkg::REG_CAL_OFFSET, 8'hFF);
		add_item(12'd4094, 1'b1, 14'sd128, 1'b1);
		add_reg(sma_pkg::REG_WINDOW_LENGTH, 8'hE0);
		add_item(12'd10, 1'b1, 14'sd11, 1'b0);
		add_reg(sma_pkg::REG_WINDOW_LENGTH, 8'h1F);
		add_item(12'd4095, 1'b0, '0, 1'b0);
		add_item(12'hAAA, 1'b0, '0, 1'b0);
		add_reg(REG_SPARE_2, 8'h01);
		add_reg(REG_SPARE_3, 8'hFF);
		add_item(12'h555, 1'b0, '0, 1'b0);
		add_reg(sma_pkg::REG_WINDOW_LENGTH, 8'd16);
		add_item(12'd1, 1'b0, '0, 1'b0);
		add_reg(sma_pkg::REG_CAL_OFFSET, 8'h7F);
		add_reg(sma_pkg::REG_WINDOW_LENGTH, 8'd2);
		add_item(12'd0, 1'b0, '0, 1'b0);
		add_item(12'd0, 1'b0, '0, 1'b0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_reg) begin
				drain_filter();
				write_reg(directed_rows[i].idx, directed_rows[i].data);
			end else begin
				offer_reading(directed_rows[i].raw, directed_rows[i].known,
					directed_rows[i].avg, directed_rows[i].fault);
			end
		end

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			drain_filter();
			if (phase == 1) begin
				len_data = 8'd16;
				off_data = 8'h80;
			end else if (phase == 2) begin
				len_data = 8'd1;
				off_data = 8'h7F;
			end else begin
				len_data = $urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255))
					: 8'($urandom_range(1, 16));
				off_data = $urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255))
					: 8'($urandom_range(0, 16) - 8);
			end
			if (phase < 3 || $urandom_range(0, 3) != 0)
				write_reg(sma_pkg::REG_WINDOW_LENGTH, len_data);
			write_reg(sma_pkg::REG_CAL_OFFSET, off_data);
			if ($urandom_range(0, 3) == 0)
				write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
					8'($urandom_range(0, 255)));
			for (int n = 0; n < PHASE_ITEMS; n++)
				offer_reading(draw_reading(), 1'b0, '0, 1'b0);
		end

		drain_filter();
		repeat (40) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
